>>> rtl/core/cfr_pkg.sv
package cfr_pkg;

	localparam int NUM_LINES  = 4;
	localparam int LEN_W      = 14;
	localparam int GAIN_W     = 16;
	localparam int GAIN_SHIFT = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_W      = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRESET  = 2'd0,
		CFG_VARIANT = 2'd1,
		CFG_TAPS    = 2'd2
	} cfg_idx_t;

	// [variant][preset][line]
	localparam logic [LEN_W-1:0] LEN_TABLE [2][4][NUM_LINES] = '{
		'{
			'{14'd2063, 14'd1847, 14'd1523, 14'd1277},
			'{14'd3089, 14'd2927, 14'd2801, 14'd2111},
			'{14'd5479, 14'd5077, 14'd4987, 14'd4057},
			'{14'd9929, 14'd7411, 14'd4951, 14'd1063}
		},
		'{
			'{14'd2053, 14'd1867, 14'd1531, 14'd1259},
			'{14'd3109, 14'd2939, 14'd2803, 14'd2113},
			'{14'd5477, 14'd5059, 14'd4993, 14'd4051},
			'{14'd9949, 14'd7393, 14'd4957, 14'd1097}
		}
	};

	// Q0.15 feedback gains, already negated
	localparam logic signed [GAIN_W-1:0] FB_GAIN_NEG [NUM_LINES] = '{
		-16'sd28616, -16'sd26945, -16'sd27895, -16'sd27863
	};

	// 0.3 in Q0.15
	localparam logic signed [GAIN_W-1:0] OUT_SCALE = 16'sd9830;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REDUCE,
		ST_READ,
		ST_DRAIN,
		ST_DIV_LOAD,
		ST_DIV,
		ST_AVG,
		ST_MUL,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic take_in;
		logic reduce;
		logic tap_read;
		logic div_load;
		logic div_step;
		logic comb_sum;
		logic fb_mul;
		logic write_back;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic ptr_wrap;
		logic tap_last;
		logic div_last;
		logic out_busy;
	} stat_t;

endpackage

>>> rtl/core/cfr_ctrl.sv
module cfr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  cfr_pkg::stat_t stat,
	output cfr_pkg::cmd_t  cmd
);
	import cfr_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_d     = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				if (stat.ptr_wrap) begin
					cmd.reduce = 1'b1;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.tap_read = 1'b1;
				if (stat.tap_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DIV_LOAD;
			end
			ST_DIV_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_AVG;
				end
			end
			ST_AVG: begin
				cmd.comb_sum = 1'b1;
				state_d      = ST_MUL;
			end
			ST_MUL: begin
				cmd.fb_mul = 1'b1;
				state_d    = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.write_back = 1'b1;
				state_d        = ST_DONE;
			end
			ST_DONE: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// taps are read only once every pointer is back inside its line
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tap_read |-> !stat.ptr_wrap)
		else $error("tap read with pointer outside line");

	a_div_to_avg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step && stat.div_last |=> cmd.comb_sum)
		else $error("average not taken after last divide step");

	a_ready_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> $past(cmd.out_load) || $past(state_q == ST_CLEAR))
		else $error("ready raised without finishing a word");

endmodule

>>> rtl/core/cfr_lane.sv
module cfr_lane #(
	parameter int LANE  = 0,
	parameter int SW    = 24,
	parameter int AW    = 14,
	parameter int TAP_W = 4,
	parameter int DEPTH = 16384
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfr_pkg::cmd_t        cmd,
	input  logic [1:0]           preset,
	input  logic                 variant,
	input  logic [TAP_W:0]       off,
	input  logic [TAP_W:0]       divisor,
	input  logic [AW-1:0]        clr_addr,
	input  logic signed [SW-1:0] dry,
	output logic signed [SW-1:0] comb,
	output logic                 ptr_wrap
);
	import cfr_pkg::*;

	localparam int SUM_W  = SW + TAP_W;
	localparam int REM_W  = TAP_W + 2;
	localparam int PROD_W = SW + GAIN_W;

	logic signed [SW-1:0]    mem [DEPTH];
	logic signed [SW-1:0]    rd_s1;
	logic                    rvalid_s1;
	logic [LEN_W-1:0]        len;
	logic [LEN_W-1:0]        ptr_q;
	logic [LEN_W-1:0]        ptr_inc;
	logic [LEN_W:0]          tap_sum;
	logic [LEN_W-1:0]        rd_addr;
	logic signed [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0]        mag;
	logic [SUM_W-1:0]        quo_q;
	logic [REM_W-1:0]        rem_q;
	logic [REM_W-1:0]        trial;
	logic                    ge;
	logic                    neg_q;
	logic signed [SW:0]      qmag;
	logic signed [SW:0]      avg;
	logic signed [SW+1:0]    csum;
	logic signed [SW-1:0]    c_next;
	logic signed [SW-1:0]    c_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W:0]  rnd;
	logic signed [SW+1:0]    fb_wide;
	logic signed [SW-1:0]    fb;

	assign len      = LEN_TABLE[variant][preset][LANE];
	assign ptr_wrap = ptr_q >= len;
	assign ptr_inc  = ptr_q + LEN_W'(1);
	assign tap_sum  = {1'b0, ptr_q} + (LEN_W+1)'(off);
	assign rd_addr  = (tap_sum >= {1'b0, len}) ? LEN_W'(tap_sum - {1'b0, len})
	                                           : tap_sum[LEN_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			mem[clr_addr] <= '0;
		end else if (cmd.write_back) begin
			mem[AW'(ptr_q)] <= fb;
		end
		rd_s1 <= mem[AW'(rd_addr)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= cmd.tap_read;
			if (cmd.reduce && ptr_wrap) begin
				ptr_q <= ptr_q - len;
			end else if (cmd.write_back) begin
				ptr_q <= (ptr_inc == len) ? '0 : ptr_inc;
			end
		end
	end

	// tap accumulate, then restoring divide by taps+1 on the magnitude
	assign mag   = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);
	assign trial = {rem_q[REM_W-2:0], quo_q[SUM_W-1]};
	assign ge    = trial >= REM_W'(divisor);

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			acc_q <= '0;
		end else if (rvalid_s1) begin
			acc_q <= acc_q + SUM_W'(rd_s1);
		end
		if (cmd.div_load) begin
			neg_q <= acc_q[SUM_W-1];
			quo_q <= mag;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? trial - REM_W'(divisor) : trial;
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign qmag = {1'b0, quo_q[SW-1:0]};
	assign avg  = neg_q ? -qmag : qmag;
	assign csum = (SW+2)'(dry) + (SW+2)'(avg);

	always_comb begin
		if (csum[SW+1:SW-1] == '0 || csum[SW+1:SW-1] == '1) begin
			c_next = csum[SW-1:0];
		end else if (csum[SW+1]) begin
			c_next = {1'b1, {(SW-1){1'b0}}};
		end else begin
			c_next = {1'b0, {(SW-1){1'b1}}};
		end
	end

	assign rnd     = (PROD_W+1)'(prod_q) + (PROD_W+1)'(2**(GAIN_SHIFT-1));
	assign fb_wide = rnd[PROD_W:GAIN_SHIFT];

	always_comb begin
		if (fb_wide[SW+1:SW-1] == '0 || fb_wide[SW+1:SW-1] == '1) begin
			fb = fb_wide[SW-1:0];
		end else if (fb_wide[SW+1]) begin
			fb = {1'b1, {(SW-1){1'b0}}};
		end else begin
			fb = {1'b0, {(SW-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.comb_sum) begin
			c_q <= c_next;
		end
		if (cmd.fb_mul) begin
			prod_q <= c_q * FB_GAIN_NEG[LANE];
		end
	end

	assign comb = c_q;

	a_wr_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_back |-> ptr_q < len)
		else $error("write-back pointer outside line");

	a_rd_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tap_read |-> rd_addr < len)
		else $error("tap address outside line");

	// last tap must be summed before the divider samples the sum
	a_acc_settled: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_load |-> !rvalid_s1)
		else $error("divider loaded with tap still pending");

endmodule

>>> rtl/core/cfr_dpath.sv
module cfr_dpath #(
	parameter int SW       = 24,
	parameter int AW       = 14,
	parameter int TAP_W    = 4,
	parameter int MAX_TAPS = 15,
	parameter int DEPTH    = 16384
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cfr_pkg::cmd_t                     cmd,
	output cfr_pkg::stat_t                    stat,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cfr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cfr_pkg::CFG_W-1:0]         cfg_data,
	input  logic signed [SW-1:0]              dry_sample,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [SW-1:0]              wet_sample
);
	import cfr_pkg::*;

	localparam int SUM_W   = SW + TAP_W;
	localparam int CNT_W   = $clog2(SUM_W);
	localparam int TOT_W   = SW + 3;
	localparam int OPROD_W = TOT_W + GAIN_W;
	localparam int ORND_W  = OPROD_W + 1;
	localparam int OW_W    = ORND_W - GAIN_SHIFT;

	logic [1:0]                 preset_q;
	logic                       variant_q;
	logic [CFG_W-1:0]           taps_q;
	logic [TAP_W-1:0]           teff;
	logic [TAP_W:0]             divisor;
	logic [TAP_W:0]             off_q;
	logic [AW-1:0]              clr_q;
	logic [CNT_W-1:0]           cnt_q;
	logic signed [SW-1:0]       dry_q;
	logic signed [SW-1:0]       c_arr [NUM_LINES];
	logic [NUM_LINES-1:0]       wrap;
	logic signed [TOT_W-1:0]    tsum;
	logic signed [TOT_W-1:0]    total_q;
	logic signed [OPROD_W-1:0]  oprod_q;
	logic signed [ORND_W-1:0]   ornd;
	logic signed [OW_W-1:0]     ow;
	logic signed [SW-1:0]       wet_next;
	logic signed [SW-1:0]       out_q;
	logic                       out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_q  <= '0;
			variant_q <= 1'b0;
			taps_q    <= CFG_W'(4);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PRESET:  preset_q  <= cfg_data[1:0];
				CFG_VARIANT: variant_q <= cfg_data[0];
				CFG_TAPS:    taps_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (int'(taps_q) > MAX_TAPS) begin
			teff = TAP_W'(MAX_TAPS);
		end else begin
			teff = TAP_W'(taps_q);
		end
	end

	assign divisor = {1'b0, teff} + (TAP_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			clr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.take_in) begin
				off_q <= '0;
			end else if (cmd.tap_read) begin
				off_q <= off_q + (TAP_W+1)'(2);
			end
			if (cmd.clear) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.div_load) begin
				cnt_q <= CNT_W'(SUM_W - 1);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			dry_q <= dry_sample;
		end
	end

	for (genvar i = 0; i < NUM_LINES; i++) begin : g_lane
		cfr_lane #(
			.LANE  (i),
			.SW    (SW),
			.AW    (AW),
			.TAP_W (TAP_W),
			.DEPTH (DEPTH)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.preset   (preset_q),
			.variant  (variant_q),
			.off      (off_q),
			.divisor  (divisor),
			.clr_addr (clr_q),
			.dry      (dry_q),
			.comb     (c_arr[i]),
			.ptr_wrap (wrap[i])
		);
	end

	always_comb begin
		stat          = '0;
		stat.clr_last = clr_q == AW'(DEPTH - 1);
		stat.ptr_wrap = |wrap;
		stat.tap_last = off_q == {teff, 1'b0};
		stat.div_last = cnt_q == '0;
		stat.out_busy = out_valid_q && !out_ready;
	end

	always_comb begin
		tsum = TOT_W'(dry_q >>> 1);
		for (int i = 0; i < NUM_LINES; i++) begin
			tsum = tsum + TOT_W'(c_arr[i]);
		end
	end

	assign ornd = ORND_W'(oprod_q) + ORND_W'(2**(GAIN_SHIFT-1));
	assign ow   = ornd[ORND_W-1:GAIN_SHIFT];

	always_comb begin
		if (ow[OW_W-1:SW-1] == '0 || ow[OW_W-1:SW-1] == '1) begin
			wet_next = ow[SW-1:0];
		end else if (ow[OW_W-1]) begin
			wet_next = {1'b1, {(SW-1){1'b0}}};
		end else begin
			wet_next = {1'b0, {(SW-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fb_mul) begin
			total_q <= tsum;
		end
		if (cmd.write_back) begin
			oprod_q <= total_q * OUT_SCALE;
		end
		if (cmd.out_load) begin
			out_q <= wet_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign wet_sample = out_q;

endmodule

>>> rtl/core/comb_filter_reverb.sv
// Four-line comb reverb: one dry word in, one wet word out, signed Q4.19 with
// saturation. After reset the block sweeps all four delay memories to zero,
// one entry per line per cycle, so in_ready stays low until the sweep is
// done; configuration writes are taken at any time but must only be issued
// while the block is idle. For each word the block first folds any pointer
// that lies beyond a shorter line after a preset change back into it by
// subtract passes (none in steady state, at most 4), then reads the taps,
// their number set by the effective extra tap count (one delay memory read
// per tap and line, all four lines in parallel), forms the tap average with
// the bit-serial divider and waits for the previous word to leave the
// output register. A finished word waits in the output register while the
// next dry word is accepted.
module comb_filter_reverb #(
	parameter int LINE_DEPTH     = 16384,
	parameter int SAMPLE_WIDTH   = 24,
	parameter int MAX_EXTRA_TAPS = 15
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cfr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cfr_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]      dry_sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]      wet_sample
);
	import cfr_pkg::*;

	localparam int AW    = $clog2(LINE_DEPTH);
	localparam int TAP_W = $clog2(MAX_EXTRA_TAPS + 1);

	cmd_t  cmd;
	stat_t stat;

	cfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cfr_dpath #(
		.SW       (SAMPLE_WIDTH),
		.AW       (AW),
		.TAP_W    (TAP_W),
		.MAX_TAPS (MAX_EXTRA_TAPS),
		.DEPTH    (LINE_DEPTH)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.dry_sample (dry_sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.wet_sample (wet_sample)
	);

endmodule
